// ===== hw/rtl/kmp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kmp_pkg
// Shared constants, types and controller/datapath links for the streaming
// Knuth-Morris-Pratt matcher.
// ----------------------------------------------------------------------------
package kmp_pkg;

	localparam int MAX_PATTERN = 8;
	localparam int MAX_TEXT    = 65536;

	localparam int CHAR_W  = 8;
	localparam int LEN_W   = $clog2(MAX_PATTERN + 1);
	localparam int IDX_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int PAT_W   = MAX_PATTERN * CHAR_W;
	localparam int POS_W   = 16;
	localparam int FAIL_W  = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 64;
	localparam int LEN_CFG_W  = 4;

	localparam logic [FAIL_W-1:0] FAIL_NONE = '1;

	// Last position the counter reaches: the smaller of MAX_TEXT-1 and the
	// largest value of the position field.
	localparam logic [POS_W-1:0] POS_CAP =
		((MAX_TEXT - 1) > ((1 << POS_W) - 1)) ? '1 : POS_W'(MAX_TEXT - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_CHARS  = 1'b0,
		REG_PATTERN_LENGTH = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BUILD_INIT,
		ST_BUILD,
		ST_MATCH,
		ST_HIT,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic build_init;
		logic build_step;
		logic match_step;
		logic hit_fallback;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic need_build;
		logic build_done;
		logic match_fall;
		logic match_hit;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/kmp_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kmp_in_if
// Text byte channel: valid/ready with one character and text framing marks.
// ----------------------------------------------------------------------------
interface kmp_in_if;
	import kmp_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] text_byte;
	logic              start_of_text;
	logic              end_of_text;

	modport source (output valid, text_byte, start_of_text, end_of_text, input ready);
	modport sink   (input valid, text_byte, start_of_text, end_of_text, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/kmp_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kmp_out_if
// Result channel: valid/ready with the hit flag, start position and failure.
// ----------------------------------------------------------------------------
interface kmp_out_if;
	import kmp_pkg::*;

	logic             valid;
	logic             ready;
	logic             match_found;
	logic [POS_W-1:0] match_start;
	logic             search_failed;

	modport source (output valid, match_found, match_start, search_failed, input ready);
	modport sink   (input valid, match_found, match_start, search_failed, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/kmp_cfg_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kmp_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface kmp_cfg_if;
	import kmp_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/kmp_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kmp_ctrl
// Sequencer: steps the table build, the fallback search and the result load.
// ----------------------------------------------------------------------------
module kmp_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  kmp_pkg::dp_status_t sts,
	output kmp_pkg::dp_cmd_t    cmd
);
	import kmp_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = sts.need_build ? ST_BUILD_INIT : ST_MATCH;
				end
			end
			ST_BUILD_INIT: begin
				cmd.build_init = 1'b1;
				state_d        = ST_BUILD;
			end
			ST_BUILD: begin
				if (sts.build_done) begin
					state_d = ST_MATCH;
				end else begin
					cmd.build_step = 1'b1;
				end
			end
			ST_MATCH: begin
				cmd.match_step = 1'b1;
				priority if (sts.match_fall) begin
					state_d = ST_MATCH;
				end else if (sts.match_hit) begin
					state_d = ST_HIT;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_HIT: begin
				cmd.hit_fallback = 1'b1;
				state_d          = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/kmp_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kmp_dp
// Datapath: config registers, latched pattern, failure table, match state
// and the result register.
// ----------------------------------------------------------------------------
module kmp_dp (
	input  wire                            clk,
	input  wire                            arst_n,
	// configuration writes
	input  wire                            cfg_we,
	input  wire  [kmp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire  [kmp_pkg::CFG_DATA_W-1:0] cfg_data,
	// input payload
	input  wire  [kmp_pkg::CHAR_W-1:0]     text_byte,
	input  wire                            start_of_text,
	input  wire                            end_of_text,
	// result
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic                           match_found,
	output logic [kmp_pkg::POS_W-1:0]      match_start,
	output logic                           search_failed,
	// sequencer link
	input  kmp_pkg::dp_cmd_t               cmd,
	output kmp_pkg::dp_status_t            sts
);
	import kmp_pkg::*;

	// configuration registers
	logic [PAT_W-1:0]     cfg_chars_q;
	logic [LEN_CFG_W-1:0] cfg_len_q;

	// per-text state
	logic [PAT_W-1:0]  pat_q;
	logic [LEN_W-1:0]  len_q;
	logic [FAIL_W-1:0] fail_q [MAX_PATTERN+1];
	logic              built_q;
	logic [LEN_W-1:0]  j_q;
	logic [POS_W-1:0]  pos_q;
	logic              any_hit_q;
	logic              hit_q;

	// current item and build counters
	logic [CHAR_W-1:0] byte_q;
	logic              eot_q;
	logic [LEN_W-1:0]  i_q;
	logic [IDX_W-1:0]  k_q;

	logic              out_valid_q;

	logic [CHAR_W-1:0] ch_i, ch_k, ch_j;
	logic [LEN_W-1:0]  rd_addr;
	logic [FAIL_W-1:0] fail_rd;
	logic [LEN_W-1:0]  j_next;
	logic [IDX_W-1:0]  k_next;
	logic [LEN_W-1:0]  len_clamped;
	logic              build_fall;

	assign ch_i = pat_q[i_q[IDX_W-1:0]*CHAR_W +: CHAR_W];
	assign ch_k = pat_q[k_q*CHAR_W +: CHAR_W];
	assign ch_j = pat_q[j_q[IDX_W-1:0]*CHAR_W +: CHAR_W];

	// one table read port, shared by build and match
	assign rd_addr = (cmd.match_step || cmd.hit_fallback) ? j_q : LEN_W'(k_q);
	assign fail_rd = fail_q[rd_addr];

	assign build_fall = (k_q != '0) && (ch_i != ch_k);
	assign k_next     = k_q + IDX_W'(ch_i == ch_k);
	assign j_next     = j_q + LEN_W'(byte_q == ch_j);

	always_comb begin
		if (cfg_len_q == '0) begin
			len_clamped = LEN_W'(1);
		end else if (LEN_CFG_W'(cfg_len_q) > LEN_CFG_W'(MAX_PATTERN)) begin
			len_clamped = LEN_W'(MAX_PATTERN);
		end else begin
			len_clamped = LEN_W'(cfg_len_q);
		end
	end

	assign sts.need_build = start_of_text || !built_q;
	assign sts.build_done = (i_q >= len_q);
	assign sts.match_fall = (j_q != '0) && (byte_q != ch_j);
	assign sts.match_hit  = !sts.match_fall && (j_next == len_q);
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;

	// control and reset-visible state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_chars_q <= '0;
			cfg_len_q   <= LEN_CFG_W'(1);
			pat_q       <= '0;
			len_q       <= LEN_W'(1);
			built_q     <= 1'b0;
			j_q         <= '0;
			pos_q       <= '0;
			any_hit_q   <= 1'b0;
			hit_q       <= 1'b0;
			i_q         <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_PATTERN_CHARS:  cfg_chars_q <= cfg_data[PAT_W-1:0];
					REG_PATTERN_LENGTH: cfg_len_q   <= cfg_data[LEN_CFG_W-1:0];
					default: ;
				endcase
			end

			if (cmd.accept && !sts.need_build && (j_q >= len_q)) begin
				j_q <= '0;
			end

			if (cmd.build_init) begin
				pat_q     <= cfg_chars_q;
				len_q     <= len_clamped;
				built_q   <= 1'b1;
				j_q       <= '0;
				pos_q     <= '0;
				any_hit_q <= 1'b0;
				i_q       <= LEN_W'(1);
				k_q       <= '0;
			end

			if (cmd.build_step) begin
				if (build_fall) begin
					k_q <= fail_rd[IDX_W-1:0];
				end else begin
					k_q <= k_next;
					i_q <= i_q + LEN_W'(1);
				end
			end

			if (cmd.match_step) begin
				if (sts.match_fall) begin
					j_q <= fail_rd[LEN_W-1:0];
				end else begin
					j_q   <= j_next;
					hit_q <= sts.match_hit;
				end
			end

			if (cmd.hit_fallback) begin
				j_q <= fail_rd[LEN_W-1:0];
			end

			if (cmd.emit) begin
				any_hit_q <= any_hit_q || hit_q;
				if (pos_q < POS_CAP) begin
					pos_q <= pos_q + POS_W'(1);
				end
				if (eot_q) begin
					built_q <= 1'b0;
				end
			end

			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload: captured item, failure table, result fields
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			byte_q <= text_byte;
			eot_q  <= end_of_text;
		end
		if (cmd.build_init) begin
			fail_q[0] <= FAIL_NONE;
			fail_q[1] <= '0;
		end
		if (cmd.build_step && !build_fall) begin
			fail_q[i_q + LEN_W'(1)] <= FAIL_W'(k_next);
		end
		if (cmd.emit) begin
			match_found   <= hit_q;
			match_start   <= hit_q ? (pos_q + POS_W'(1) - POS_W'(len_q)) : '0;
			search_failed <= eot_q && !(any_hit_q || hit_q);
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/kmp_stream_matcher_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kmp_stream_matcher_unit
// Streaming Knuth-Morris-Pratt matcher for a pattern of up to eight bytes.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake        payload
//  --------  ---  ---------------  ------------------------------------------
//  text_in   in   valid / ready    text_byte, start_of_text, end_of_text
//  result    out  valid / ready    match_found, match_start, search_failed
//  cfg       in   valid / ready    index, data (0: pattern_chars,
//                                  1: pattern_length)
//
//  Steps: a byte that continues a text is accepted in IDLE, then runs MATCH
//  once plus once more per failure-table fallback, then EMIT; a hit adds
//  a HIT step for the fallback after the match. The first byte of a text
//  runs BUILD_INIT and then the BUILD steps of the table build first.
//  Build and match share the single table read port, one lookup per cycle.
//  Reset clears the match state and leaves the failure table unwritten;
//  the first byte after reset always rebuilds it.
//  Stalls: a finished result waits in the output register while the next
//  beat is taken; the block holds in its emit step only if that register
//  is still full and not taken when the next result is ready.
//  Config is always ready; a new pattern takes effect at the next text.
// ----------------------------------------------------------------------------
module kmp_stream_matcher_unit (
	input  wire      clk,
	input  wire      arst_n,
	kmp_in_if.sink   text_in,
	kmp_out_if.source result,
	kmp_cfg_if.sink  cfg
);
	import kmp_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t sts;

	// Config writes land directly in registers, so never stall the port.
	assign cfg.ready = 1'b1;

	// Sequencer: owns the input ready and steps the datapath.
	kmp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (text_in.valid),
		.in_ready (text_in.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: registers, table and result beat.
	kmp_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg.valid && cfg.ready),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.text_byte     (text_in.text_byte),
		.start_of_text (text_in.start_of_text),
		.end_of_text   (text_in.end_of_text),
		.out_valid     (result.valid),
		.out_ready     (result.ready),
		.match_found   (result.match_found),
		.match_start   (result.match_start),
		.search_failed (result.search_failed),
		.cmd           (cmd),
		.sts           (sts)
	);

endmodule

`default_nettype wire
